>>> rtl/hgc_pkg.sv
// Shared constants, codes and control/status types for the group-by count engine.
package hgc_pkg;

  localparam int DEPTH   = 1024;            // table depth, a power of two
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = AW + 1;          // scan index / read cursor width
  localparam int KW      = 64;
  localparam int CW      = 32;
  localparam int HALF    = DEPTH / 2;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb93fe53ec4f9;

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  typedef enum logic [3:0] {
    RES_SKIP,
    RES_FULL,
    RES_NEW,
    RES_INC,
    RES_HIT_LAST,
    RES_HIT_MORE,
    RES_END,
    RES_ZERO,
    RES_BAD
  } res_t;

  typedef struct packed {
    logic load_in;
    logic hash_start;
    logic pos_load;
    logic pos_inc;
    logic rd_scan;
    logic scan_zero;
    logic scan_cursor;
    logic scan_inc;
    logic clr_wr;
    logic take_hit;
    logic set_res;
    res_t res;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic hash_done;
    logic used;
    logic match;
    logic full;
    logic scan_end;
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/hash_group_count_top.sv
// Top level: configuration register, controller and datapath.
// Count request: accept, decode, hash (shared 32x32 multiplier, iterated rounds), a RAM read and evaluate
//   per probe, then hand-off to the output register.
// Read-next: from the cursor, a RAM read and evaluate per slot scanned, then hand-off.
// Clear: a write to every slot, then hand-off of a zero result.
// One request at a time; the output register frees the input while a result waits.
// After reset a clearing pass over every slot runs with in_stall high; config writes still work.
module hash_group_count_top
  import hgc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    cmd,
  input  logic [KW-1:0] value,
  input  logic          keep,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [KW-1:0] key,
  output logic [CW-1:0] count,
  output logic [AW-1:0] distinct_keys,
  output logic [CW-1:0] largest_count,
  output logic          last_entry,
  output logic [1:0]    status
);

  logic [1:0] value_type;
  ctrl_t      ctl;
  stat_t      sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'b0 : {30'b0, value_type};

  always_ff @(posedge clk) begin
    if (rst) begin
      value_type <= 2'd3;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      value_type <= pwdata[1:0];
    end
  end

  hgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .keep     (keep),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  hgc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .value_type    (value_type),
    .value         (value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .key           (key),
    .count         (count),
    .distinct_keys (distinct_keys),
    .largest_count (largest_count),
    .last_entry    (last_entry),
    .status        (status)
  );

endmodule

>>> rtl/hgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/hgc_hash.sv
// Iterative 64-bit finalizer hash on one shared 32x32 multiplier.
module hgc_hash
  import hgc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [KW-1:0] key_in,
  output logic          done,
  output logic [AW-1:0] idx
);

  typedef enum logic [2:0] {H_IDLE, H_M0, H_M1, H_M2, H_SUM} hph_t;

  hph_t        ph;
  logic        pass;
  logic [63:0] x;
  logic [63:0] p0, p1, p2;
  logic [63:0] c;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [31:0] hi;
  logic [63:0] m;

  assign c    = pass ? MIX_C2 : MIX_C1;
  assign op_a = (ph == H_M2) ? x[63:32] : x[31:0];
  assign op_b = (ph == H_M1) ? c[63:32] : c[31:0];
  assign prod = 64'(op_a) * 64'(op_b);
  // only the low 64 bits of the full product are kept
  assign hi   = p1[31:0] + p2[31:0];
  assign m    = p0 + {hi, 32'b0};
  assign idx  = x[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= H_IDLE;
      pass <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        H_IDLE: begin
          if (start) begin
            x    <= key_in ^ (key_in >> 33);
            pass <= 1'b0;
            ph   <= H_M0;
          end
        end
        H_M0: begin
          p0 <= prod;
          ph <= H_M1;
        end
        H_M1: begin
          p1 <= prod;
          ph <= H_M2;
        end
        H_M2: begin
          p2 <= prod;
          ph <= H_SUM;
        end
        H_SUM: begin
          x <= m ^ (m >> 33);
          if (pass) begin
            done <= 1'b1;
            ph   <= H_IDLE;
          end else begin
            pass <= 1'b1;
            ph   <= H_M0;
          end
        end
        default: ph <= H_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/hgc_dp.sv
// Datapath: key capture, hash, slot RAMs, counters, cursor and output register.
module hgc_dp
  import hgc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  ctrl_t         ctl,
  output stat_t         sts,
  input  logic [1:0]    value_type,
  input  logic [KW-1:0] value,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [KW-1:0] key,
  output logic [CW-1:0] count,
  output logic [AW-1:0] distinct_keys,
  output logic [CW-1:0] largest_count,
  output logic          last_entry,
  output logic [1:0]    status
);

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] HALF_A  = AW'(HALF);
  localparam logic [CW-1:0] CMAX    = '1;

  logic [KW-1:0] key_q, widened;
  logic [AW-1:0] pos, occ;
  logic [SW-1:0] scan, cursor;
  logic [CW-1:0] peak;
  logic [KW-1:0] res_key;
  logic [CW-1:0] res_cnt;
  logic          res_last;
  logic [1:0]    res_st;

  logic          hash_done;
  logic [AW-1:0] hash_idx;
  logic [KW-1:0] key_rd;
  logic [CW:0]   cnt_rd;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] raddr, waddr;
  logic          key_we, cnt_we;
  logic [CW:0]   cnt_wdata;

  always_comb begin
    case (value_type)
      2'd0:    widened = {{56{value[7]}}, value[7:0]};
      2'd1:    widened = {{48{value[15]}}, value[15:0]};
      2'd2:    widened = {{32{value[31]}}, value[31:0]};
      default: widened = value;
    endcase
  end

  hgc_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.hash_start),
    .key_in (key_q),
    .done   (hash_done),
    .idx    (hash_idx)
  );

  assign cnt_inc = (cnt_rd[CW-1:0] == CMAX) ? cnt_rd[CW-1:0] : cnt_rd[CW-1:0] + 1'b1;
  assign raddr   = ctl.rd_scan ? scan[AW-1:0] : pos;
  assign waddr   = ctl.clr_wr ? scan[AW-1:0] : pos;
  assign key_we  = ctl.set_res && (ctl.res == RES_NEW);
  assign cnt_we  = ctl.clr_wr || (ctl.set_res && (ctl.res == RES_NEW || ctl.res == RES_INC));

  always_comb begin
    if (ctl.clr_wr) begin
      cnt_wdata = '0;
    end else if (ctl.res == RES_NEW) begin
      cnt_wdata = {1'b1, CW'(1)};
    end else begin
      cnt_wdata = {1'b1, cnt_inc};
    end
  end

  hgc_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_q),
    .raddr (raddr),
    .rdata (key_rd)
  );

  // top bit is the slot's used flag
  hgc_ram #(.WIDTH(CW + 1), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  assign sts.hash_done = hash_done;
  assign sts.used      = cnt_rd[CW];
  assign sts.match     = (key_rd == key_q);
  assign sts.full      = (occ >= HALF_A);
  assign sts.scan_end  = (scan == DEPTH_S);
  assign sts.scan_last = (scan[AW-1:0] == {AW{1'b1}});
  assign sts.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      key_q <= widened;
    end
    if (ctl.pos_load) begin
      pos <= hash_idx;
    end else if (ctl.pos_inc) begin
      pos <= pos + 1'b1;
    end
    if (ctl.take_hit) begin
      res_key <= key_rd;
      res_cnt <= cnt_rd[CW-1:0];
    end
    if (ctl.set_res) begin
      case (ctl.res)
        RES_SKIP: begin
          res_key <= key_q; res_cnt <= '0; res_last <= 1'b0; res_st <= ST_SKIP;
        end
        RES_FULL: begin
          res_key <= key_q; res_cnt <= '0; res_last <= 1'b0; res_st <= ST_FULL;
        end
        RES_NEW: begin
          res_key <= key_q; res_cnt <= CW'(1); res_last <= 1'b0; res_st <= ST_OK;
        end
        RES_INC: begin
          res_key <= key_q; res_cnt <= cnt_inc; res_last <= 1'b0; res_st <= ST_OK;
        end
        RES_HIT_LAST: begin
          res_last <= 1'b1; res_st <= ST_OK;
        end
        RES_HIT_MORE: begin
          res_last <= 1'b0; res_st <= ST_OK;
        end
        RES_END: begin
          res_key <= '0; res_cnt <= '0; res_last <= 1'b1; res_st <= ST_END;
        end
        RES_ZERO: begin
          res_key <= '0; res_cnt <= '0; res_last <= 1'b0; res_st <= ST_OK;
        end
        default: begin
          res_key <= '0; res_cnt <= '0; res_last <= 1'b0; res_st <= ST_SKIP;
        end
      endcase
    end
    if (ctl.emit) begin
      key           <= res_key;
      count         <= res_cnt;
      distinct_keys <= occ;
      largest_count <= peak;
      last_entry    <= res_last;
      status        <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      peak      <= '0;
      cursor    <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.emit || (out_valid && out_stall);
      if (ctl.scan_zero) begin
        scan <= '0;
      end else if (ctl.scan_cursor) begin
        scan <= cursor;
      end else if (ctl.scan_inc || ctl.clr_wr) begin
        scan <= scan + 1'b1;
      end
      if (ctl.take_hit) begin
        cursor <= scan + 1'b1;
      end
      if (ctl.set_res) begin
        case (ctl.res)
          RES_NEW: begin
            occ <= occ + 1'b1;
            if (peak == '0) begin
              peak <= CW'(1);
            end
          end
          RES_INC: begin
            if (cnt_inc > peak) begin
              peak <= cnt_inc;
            end
          end
          RES_END: cursor <= DEPTH_S;
          RES_ZERO: begin
            occ    <= '0;
            peak   <= '0;
            cursor <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/hgc_ctrl.sv
// Controller: sequences clearing, hashing, probing, read-next scans and result hand-off.
module hgc_ctrl
  import hgc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  input  logic       keep,
  output logic       in_stall,
  input  stat_t      sts,
  output ctrl_t      ctl
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_HASH, S_PRD, S_PEV, S_RRD, S_REV, S_FIN
  } state_t;

  state_t     state, state_next;
  logic [1:0] cmd_q;
  logic       keep_q;
  logic       found, found_next;
  logic       clr_emit, clr_emit_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl           = '0;
    ctl.res       = RES_BAD;
    state_next    = state;
    found_next    = found;
    clr_emit_next = clr_emit;
    case (state)
      S_CLR: begin
        ctl.clr_wr = 1'b1;
        if (sts.scan_last) begin
          if (clr_emit) begin
            ctl.set_res = 1'b1;
            ctl.res     = RES_ZERO;
            state_next  = S_FIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        case (cmd_q)
          CMD_COUNT: begin
            if (keep_q) begin
              ctl.hash_start = 1'b1;
              state_next     = S_HASH;
            end else begin
              ctl.set_res = 1'b1;
              ctl.res     = RES_SKIP;
              state_next  = S_FIN;
            end
          end
          CMD_READ: begin
            ctl.scan_cursor = 1'b1;
            found_next      = 1'b0;
            state_next      = S_RRD;
          end
          CMD_CLEAR: begin
            ctl.scan_zero = 1'b1;
            clr_emit_next = 1'b1;
            state_next    = S_CLR;
          end
          default: begin
            ctl.set_res = 1'b1;
            ctl.res     = RES_BAD;
            state_next  = S_FIN;
          end
        endcase
      end
      S_HASH: begin
        if (sts.hash_done) begin
          ctl.pos_load = 1'b1;
          state_next   = S_PRD;
        end
      end
      S_PRD: state_next = S_PEV;
      S_PEV: begin
        if (!sts.used) begin
          ctl.set_res = 1'b1;
          ctl.res     = sts.full ? RES_FULL : RES_NEW;
          state_next  = S_FIN;
        end else if (sts.match) begin
          ctl.set_res = 1'b1;
          ctl.res     = RES_INC;
          state_next  = S_FIN;
        end else begin
          ctl.pos_inc = 1'b1;
          state_next  = S_PRD;
        end
      end
      S_RRD: begin
        ctl.rd_scan = 1'b1;
        if (sts.scan_end) begin
          ctl.set_res = 1'b1;
          ctl.res     = found ? RES_HIT_LAST : RES_END;
          state_next  = S_FIN;
        end else begin
          state_next = S_REV;
        end
      end
      S_REV: begin
        // first used slot is the answer, the second only decides last_entry
        if (sts.used && found) begin
          ctl.set_res = 1'b1;
          ctl.res     = RES_HIT_MORE;
          state_next  = S_FIN;
        end else begin
          if (sts.used) begin
            ctl.take_hit = 1'b1;
            found_next   = 1'b1;
          end
          ctl.scan_inc = 1'b1;
          state_next   = S_RRD;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.emit      = 1'b1;
          clr_emit_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      found    <= 1'b0;
      clr_emit <= 1'b0;
      cmd_q    <= CMD_COUNT;
      keep_q   <= 1'b0;
    end else begin
      state    <= state_next;
      found    <= found_next;
      clr_emit <= clr_emit_next;
      if (ctl.load_in) begin
        cmd_q  <= cmd;
        keep_q <= keep;
      end
    end
  end

endmodule
